@@ src/ckm_pkg.sv @@
// Shared constants, types and the base coding function of the k-mer minimizer extractor.
`timescale 1ns / 1ps

package ckm_pkg;

  // Default sizes of the block.
  localparam int KMER_LEN_DEF   = 28;
  localparam int WINDOW_LEN_DEF = 16;

  // Field widths.
  localparam int CHAR_W = 8;
  localparam int SEQ_W  = 40;
  localparam int MIN_W  = 56;
  localparam int MIX_W  = 64;

  // Shift amounts of the 64-bit integer mix.
  localparam int MIX_SH_A = 21;
  localparam int MIX_SH_B = 24;
  localparam int MIX_SH_C = 3;
  localparam int MIX_SH_D = 8;
  localparam int MIX_SH_E = 14;
  localparam int MIX_SH_F = 2;
  localparam int MIX_SH_G = 4;
  localparam int MIX_SH_H = 28;
  localparam int MIX_SH_I = 31;

  // ASCII nucleotides.
  localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_C = 8'h43;
  localparam logic [CHAR_W-1:0] ASCII_G = 8'h47;
  localparam logic [CHAR_W-1:0] ASCII_T = 8'h54;

  typedef logic [1:0] base_code_t;

  localparam base_code_t CODE_A = 2'd0;
  localparam base_code_t CODE_C = 2'd1;
  localparam base_code_t CODE_G = 2'd2;
  localparam base_code_t CODE_T = 2'd3;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_DECIDE,
    S_EMIT_MIN,
    S_EMIT_END
  } ckm_state_t;

  // Control that the sequencer broadcasts to every window cell.
  typedef struct packed {
    logic shift;
    logic first;
  } cell_ctrl_t;

  // Two-bit code of a nucleotide; any unknown byte codes as A.
  function automatic base_code_t base_code(input logic [CHAR_W-1:0] ch);
    base_code_t code;
    case (ch)
      ASCII_A: code = CODE_A;
      ASCII_C: code = CODE_C;
      ASCII_G: code = CODE_G;
      ASCII_T: code = CODE_T;
      default: code = CODE_A;
    endcase
    return code;
  endfunction

endpackage

@@ src/ckm_hash.sv @@
// Canonical k-mer selection and the five-stage pipelined integer mix.
`timescale 1ns / 1ps

module ckm_hash #(
  parameter int KMER_LEN = ckm_pkg::KMER_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2*KMER_LEN-1:0] kmer,
  output logic                  out_valid,
  output logic [2*KMER_LEN-1:0] hash
);

  localparam int HW = 2 * KMER_LEN;
  localparam int MW = ckm_pkg::MIX_W;

  logic [HW-1:0] rev;
  logic [HW-1:0] canon;
  logic [MW-1:0] k1, k2, k3, k4, k5, k6, k7;
  logic [MW-1:0] s0_r, s1_r, s2_r, s3_r;
  logic [HW-1:0] hash_r;
  logic [4:0]    vld_r;

  // Reverse complement is pure wiring: each base is inverted and mirrored.
  always_comb begin
    rev = '0;
    for (int b = 0; b < KMER_LEN; b++) begin
      rev[2*(KMER_LEN-1-b) +: 2] = ~kmer[2*b +: 2];
    end
    canon = (kmer < rev) ? kmer : rev;
  end

  // At most one add group and one xor-shift between registers.
  assign k1 = ~s0_r + (s0_r << ckm_pkg::MIX_SH_A);
  assign k2 = k1 ^ (k1 >> ckm_pkg::MIX_SH_B);
  assign k3 = s1_r + (s1_r << ckm_pkg::MIX_SH_C) + (s1_r << ckm_pkg::MIX_SH_D);
  assign k4 = k3 ^ (k3 >> ckm_pkg::MIX_SH_E);
  assign k5 = s2_r + (s2_r << ckm_pkg::MIX_SH_F) + (s2_r << ckm_pkg::MIX_SH_G);
  assign k6 = k5 ^ (k5 >> ckm_pkg::MIX_SH_H);
  assign k7 = s3_r + (s3_r << ckm_pkg::MIX_SH_I);

  // Data stages.
  always_ff @(posedge clk) begin
    s0_r   <= MW'(canon);
    s1_r   <= k2;
    s2_r   <= k4;
    s3_r   <= k6;
    hash_r <= HW'(k7);
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  assign out_valid = vld_r[4];
  assign hash      = hash_r;

endmodule

@@ src/ckm_min_cell.sv @@
// One window cell: the minimum of the newest hash and its neighbor's older minimum.
`timescale 1ns / 1ps

module ckm_min_cell #(
  parameter int HASH_W = 2 * ckm_pkg::KMER_LEN_DEF
) (
  input  logic                clk,
  input  ckm_pkg::cell_ctrl_t ctrl,
  input  logic [HASH_W-1:0]   new_hash,
  input  logic [HASH_W-1:0]   prev_min,
  output logic [HASH_W-1:0]   min_out
);

  logic [HASH_W-1:0] min_r;
  logic [HASH_W-1:0] min_nxt;

  // Cell j holds the minimum of the last j+1 hashes of the job.
  assign min_nxt = ctrl.first ? new_hash :
                   ((prev_min < new_hash) ? prev_min : new_hash);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      min_r <= min_nxt;
    end
  end

  assign min_out = min_r;

endmodule

@@ src/canonical_kmer_minimizer_extractor.sv @@
// Top level of the canonical k-mer minimizer extractor: sequencer, job state and cell chain.
//
//  Channel  Direction  Handshake            Word contents
//  in_      slave      in_tvalid/in_tready  tdata[7:0] base_char
//  out_     master     out_tvalid/tready    tdata[55:0] minimizer, [95:56] minimizer_count,
//                                           tlast end_of_job
//  cfg_     write      cfg_wr_en            cfg_wr_data[39:0] sequence_length
//
// A base that completes no k-mer goes from idle to the decide state; one that completes a
// k-mer waits in the hash state for the five register stages of the hash pipeline; the
// cells update as it leaves; each word adds an emit state. One base is in work at a time.
// Reset is synchronous and active low; it clears the job and the length register.
// A result word waits in the output register while the next base is taken in; the
// sequencer stalls only when a new word is due and the output register is still full.
`timescale 1ns / 1ps

module canonical_kmer_minimizer_extractor #(
  parameter int KMER_LEN   = ckm_pkg::KMER_LEN_DEF,
  parameter int WINDOW_LEN = ckm_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // base_char[7:0]
  input  logic [ckm_pkg::CHAR_W-1:0] in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // minimizer[55:0], minimizer_count[95:56]
  output logic [95:0]                out_tdata,
  output logic                       out_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wr_en,
  input  logic [ckm_pkg::SEQ_W-1:0]  cfg_wr_data
);

  localparam int HW     = 2 * KMER_LEN;
  localparam int FW     = $clog2(WINDOW_LEN + 1);
  localparam int SW     = ckm_pkg::SEQ_W;
  localparam int MW     = ckm_pkg::MIN_W;
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LEN);

  ckm_pkg::ckm_state_t state_r, state_nxt;

  logic [SW-1:0] seq_len_r;
  logic [HW-1:0] kmer_shift_r, kmer_shift_nxt;
  logic [SW-1:0] bases_seen_r, bases_seen_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          full_before_r, full_before_nxt;
  logic          push_r, push_nxt;
  logic          final_r, final_nxt;
  logic [HW-1:0] last_emitted_r, last_emitted_nxt;
  logic [SW-1:0] emit_cnt_r, emit_cnt_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [MW-1:0] out_min_r, out_min_nxt;
  logic [SW-1:0] out_cnt_r, out_cnt_nxt;
  logic          out_last_r, out_last_nxt;

  logic [HW-1:0] kmer_in;
  logic [SW-1:0] bases_inc;
  logic          accept;
  logic          hash_start;
  logic          hash_valid;
  logic [HW-1:0] hash;
  logic          out_free;
  logic          need_min;
  logic [HW-1:0] win_min;

  ckm_pkg::cell_ctrl_t cell_ctrl;
  logic [HW-1:0]       cell_min [WINDOW_LEN];

  // Next k-mer and base count of an incoming word.
  assign accept     = in_tvalid && in_tready;
  assign kmer_in    = HW'({kmer_shift_r, ckm_pkg::base_code(in_tdata)});
  assign bases_inc  = bases_seen_r + SW'(1);
  assign hash_start = accept && (bases_inc >= SW'(KMER_LEN));
  assign out_free   = !out_tvalid_r || out_tready;

  ckm_hash #(
    .KMER_LEN (KMER_LEN)
  ) u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hash_start),
    .kmer      (kmer_in),
    .out_valid (hash_valid),
    .hash      (hash)
  );

  // Window cells: each takes its neighbor's minimum and the broadcast hash.
  assign cell_ctrl.shift = (state_r == ckm_pkg::S_HASH) && hash_valid;
  assign cell_ctrl.first = (fill_r == '0);

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    ckm_min_cell #(
      .HASH_W (HW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .new_hash (hash),
      .prev_min ((i == 0) ? {HW{1'b1}} : cell_min[(i == 0) ? 0 : i - 1]),
      .min_out  (cell_min[i])
    );
  end

  assign win_min = cell_min[WINDOW_LEN-1];

  // A minimum is due when the window first fills, when a full window's minimum changes,
  // or when a job shorter than one window ends.
  assign need_min = (push_r && (full_before_r ? (win_min != last_emitted_r)
                                              : (fill_r == FILL_FULL)))
                 || (final_r && (fill_r != '0) && (fill_r != FILL_FULL));

  // Sequencer: next state, job state and output register loads.
  always_comb begin
    state_nxt        = state_r;
    kmer_shift_nxt   = kmer_shift_r;
    bases_seen_nxt   = bases_seen_r;
    fill_nxt         = fill_r;
    full_before_nxt  = full_before_r;
    push_nxt         = push_r;
    final_nxt        = final_r;
    last_emitted_nxt = last_emitted_r;
    emit_cnt_nxt     = emit_cnt_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_min_nxt      = out_min_r;
    out_cnt_nxt      = out_cnt_r;
    out_last_nxt     = out_last_r;
    in_tready        = 1'b0;

    case (state_r)
      ckm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kmer_shift_nxt = kmer_in;
          bases_seen_nxt = bases_inc;
          push_nxt       = hash_start;
          final_nxt      = (bases_inc == seq_len_r);
          state_nxt      = hash_start ? ckm_pkg::S_HASH : ckm_pkg::S_DECIDE;
        end
      end
      ckm_pkg::S_HASH: begin
        if (hash_valid) begin
          full_before_nxt = (fill_r == FILL_FULL);
          if (fill_r != FILL_FULL) begin
            fill_nxt = fill_r + FW'(1);
          end
          state_nxt = ckm_pkg::S_DECIDE;
        end
      end
      ckm_pkg::S_DECIDE: begin
        if (need_min) begin
          state_nxt = ckm_pkg::S_EMIT_MIN;
        end else if (final_r) begin
          state_nxt = ckm_pkg::S_EMIT_END;
        end else begin
          state_nxt = ckm_pkg::S_IDLE;
        end
      end
      ckm_pkg::S_EMIT_MIN: begin
        if (out_free) begin
          out_tvalid_nxt   = 1'b1;
          out_min_nxt      = MW'(win_min);
          out_cnt_nxt      = '0;
          out_last_nxt     = 1'b0;
          last_emitted_nxt = win_min;
          emit_cnt_nxt     = emit_cnt_r + SW'(1);
          state_nxt        = final_r ? ckm_pkg::S_EMIT_END : ckm_pkg::S_IDLE;
        end
      end
      ckm_pkg::S_EMIT_END: begin
        if (out_free) begin
          out_tvalid_nxt   = 1'b1;
          out_min_nxt      = '0;
          out_cnt_nxt      = emit_cnt_r;
          out_last_nxt     = 1'b1;
          kmer_shift_nxt   = '0;
          bases_seen_nxt   = '0;
          fill_nxt         = '0;
          last_emitted_nxt = '0;
          emit_cnt_nxt     = '0;
          state_nxt        = ckm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ckm_pkg::S_IDLE;
      end
    endcase
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ckm_pkg::S_IDLE;
      seq_len_r      <= '0;
      kmer_shift_r   <= '0;
      bases_seen_r   <= '0;
      fill_r         <= '0;
      full_before_r  <= 1'b0;
      push_r         <= 1'b0;
      final_r        <= 1'b0;
      last_emitted_r <= '0;
      emit_cnt_r     <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) begin
        seq_len_r <= cfg_wr_data;
      end
      kmer_shift_r   <= kmer_shift_nxt;
      bases_seen_r   <= bases_seen_nxt;
      fill_r         <= fill_nxt;
      full_before_r  <= full_before_nxt;
      push_r         <= push_nxt;
      final_r        <= final_nxt;
      last_emitted_r <= last_emitted_nxt;
      emit_cnt_r     <= emit_cnt_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_min_r  <= out_min_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_cnt_r, out_min_r};
  assign out_tlast  = out_last_r;

  // The fill count never passes the window length.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill count out of range");

  // An end marker never carries a minimizer value.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_last_r) |-> (out_min_r == '0))
    else $error("end marker with nonzero minimizer");

  // A hash only comes out while the sequencer waits for it.
  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hash_valid |-> (state_r == ckm_pkg::S_HASH))
    else $error("hash result arrived outside its wait state");

  // Sending the end marker clears the job.
  a_job_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ckm_pkg::S_EMIT_END && out_free)
      |=> (bases_seen_r == '0 && fill_r == '0 && emit_cnt_r == '0))
    else $error("job state not cleared after end marker");

endmodule

@@ dv/canonical_kmer_minimizer_extractor_test.sv @@
// Self-checking testbench of the canonical k-mer minimizer extractor with a built-in predictor.
`timescale 1ns / 1ps

module canonical_kmer_minimizer_extractor_test;

  localparam int CHAR_W        = ckm_pkg::CHAR_W;
  localparam int SEQ_W         = ckm_pkg::SEQ_W;
  localparam int MIN_W         = ckm_pkg::MIN_W;
  localparam int MIX_W         = ckm_pkg::MIX_W;
  localparam int KMER_LEN      = ckm_pkg::KMER_LEN_DEF;
  localparam int WIN_LEN       = ckm_pkg::WINDOW_LEN_DEF;
  localparam int KW            = 2 * KMER_LEN;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int TARGET_BASES  = 940;

  // One result word as the block presents it.
  typedef struct packed {
    logic             end_of_job;
    logic [SEQ_W-1:0] count;
    logic [MIN_W-1:0] minimizer;
  } minimizer_word_t;

  logic              clk;
  logic              rst_n;
  logic [CHAR_W-1:0] in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [95:0]       out_tdata;
  logic              out_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_wr_en;
  logic [SEQ_W-1:0]  cfg_wr_data;

  // Bases waiting to be driven and result words the predictor has produced.
  logic [CHAR_W-1:0] base_queue[$];
  minimizer_word_t   minimizer_words[$];

  // Predictor state: k-mer register, job counters and the hash window.
  logic [KW-1:0]     kmer_reg;
  logic [SEQ_W-1:0]  job_bases;
  logic [SEQ_W-1:0]  job_length;
  logic [KW-1:0]     hash_ring[WIN_LEN];
  int                ring_fill;
  int                ring_head;
  logic [KW-1:0]     ring_min;
  int                ring_min_slot;
  logic [KW-1:0]     last_minimizer;
  logic [SEQ_W-1:0]  minimizer_total;

  int  error_count;
  int  cycle_count;
  bit  in_taken;
  bit  out_taken;
  int  tx_hold;
  int  tx_calm;
  int  rx_hold;
  int  rx_calm;

  canonical_kmer_minimizer_extractor #(
    .KMER_LEN   (KMER_LEN),
    .WINDOW_LEN (WIN_LEN)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draws a per-word wait; now and then a calm stretch with no waits at all.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Two-bit code of an ASCII nucleotide; unknown bytes count as A.
  function automatic logic [1:0] code_of(logic [CHAR_W-1:0] ch);
    logic [1:0] code;
    if (ch == ckm_pkg::ASCII_C) code = ckm_pkg::CODE_C;
    else if (ch == ckm_pkg::ASCII_G) code = ckm_pkg::CODE_G;
    else if (ch == ckm_pkg::ASCII_T) code = ckm_pkg::CODE_T;
    else code = ckm_pkg::CODE_A;
    return code;
  endfunction

  // Smaller of the forward k-mer and its reverse complement.
  function automatic logic [KW-1:0] canon_kmer(logic [KW-1:0] fwd);
    logic [KW-1:0] rev;
    rev = '0;
    for (int b = 0; b < KMER_LEN; b++) begin
      rev[2*(KMER_LEN-1-b) +: 2] = 2'b11 ^ fwd[2*b +: 2];
    end
    return (fwd < rev) ? fwd : rev;
  endfunction

  // The 64-bit integer mix, cut to the k-mer width at the end.
  function automatic logic [KW-1:0] hash_kmer(logic [KW-1:0] kmer);
    logic [MIX_W-1:0] k;
    k = MIX_W'(kmer);
    k = ~k + (k << ckm_pkg::MIX_SH_A);
    k = k ^ (k >> ckm_pkg::MIX_SH_B);
    k = k + (k << ckm_pkg::MIX_SH_C) + (k << ckm_pkg::MIX_SH_D);
    k = k ^ (k >> ckm_pkg::MIX_SH_E);
    k = k + (k << ckm_pkg::MIX_SH_F) + (k << ckm_pkg::MIX_SH_G);
    k = k ^ (k >> ckm_pkg::MIX_SH_H);
    k = k + (k << ckm_pkg::MIX_SH_I);
    return k[KW-1:0];
  endfunction

  // Clears everything that belongs to one job.
  task automatic clear_job();
    kmer_reg        = '0;
    job_bases       = '0;
    ring_fill       = 0;
    ring_head       = 0;
    ring_min        = '0;
    ring_min_slot   = 0;
    last_minimizer  = '0;
    minimizer_total = '0;
    for (int p = 0; p < WIN_LEN; p++) hash_ring[p] = '0;
  endtask

  // Queues the current window minimum as a minimizer word.
  task automatic emit_minimum();
    minimizer_word_t w;
    w.minimizer  = MIN_W'(ring_min);
    w.count      = '0;
    w.end_of_job = 1'b0;
    minimizer_words.push_back(w);
    last_minimizer  = ring_min;
    minimizer_total = minimizer_total + 1'b1;
  endtask

  // Adds one hash to the window and emits a minimum when one is due.
  task automatic push_hash(logic [KW-1:0] h);
    if (ring_fill < WIN_LEN) begin
      hash_ring[ring_fill] = h;
      if (ring_fill == 0 || h < ring_min) begin
        ring_min      = h;
        ring_min_slot = ring_fill;
      end
      ring_fill++;
      if (ring_fill == WIN_LEN) emit_minimum();
    end else begin
      hash_ring[ring_head] = h;
      // The old minimum was overwritten: rescan, lowest slot wins ties.
      if (ring_min_slot == ring_head) begin
        ring_min      = hash_ring[0];
        ring_min_slot = 0;
        for (int p = 1; p < WIN_LEN; p++) begin
          if (hash_ring[p] < ring_min) begin
            ring_min      = hash_ring[p];
            ring_min_slot = p;
          end
        end
      end else if (h < ring_min) begin
        ring_min      = h;
        ring_min_slot = ring_head;
      end
      ring_head = (ring_head + 1) % WIN_LEN;
      if (ring_min != last_minimizer) emit_minimum();
    end
  endtask

  // Predicts the words caused by one accepted base.
  task automatic take_base(logic [CHAR_W-1:0] ch);
    minimizer_word_t w;
    kmer_reg  = {kmer_reg[KW-3:0], code_of(ch)};
    job_bases = job_bases + 1'b1;
    if (job_bases >= KMER_LEN) push_hash(hash_kmer(canon_kmer(kmer_reg)));
    if (job_bases == job_length) begin
      // A job shorter than one window still reports its minimum.
      if (ring_fill > 0 && ring_fill < WIN_LEN) emit_minimum();
      w.minimizer  = '0;
      w.count      = minimizer_total;
      w.end_of_job = 1'b1;
      minimizer_words.push_back(w);
      clear_job();
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Sample both handshakes, run the predictor and check result words.
  always @(posedge clk) begin
    minimizer_word_t want;
    cycle_count++;
    in_taken  = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
    if (in_taken) take_base(in_tdata);
    if (out_taken) begin
      if (minimizer_words.size() == 0) begin
        report_mismatch("word with nothing expected", out_tdata[63:0], '0);
      end else begin
        want = minimizer_words.pop_front();
        if (out_tdata[MIN_W-1:0] !== want.minimizer)
          report_mismatch("minimizer", 64'(out_tdata[MIN_W-1:0]), 64'(want.minimizer));
        if (out_tdata[MIN_W +: SEQ_W] !== want.count)
          report_mismatch("minimizer_count", 64'(out_tdata[MIN_W +: SEQ_W]), 64'(want.count));
        if (out_tlast !== want.end_of_job)
          report_mismatch("end_of_job", 64'(out_tlast), 64'(want.end_of_job));
      end
    end
  end

  // Input driver: holds a word until taken, then waits its drawn gap.
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (tx_hold > 0) begin
        in_tvalid <= 1'b0;
        tx_hold--;
      end else if (base_queue.size() > 0) begin
        in_tdata  <= base_queue.pop_front();
        in_tvalid <= 1'b1;
        tx_hold   = draw_wait(tx_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: after each word taken, stall ready for a drawn count.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) rx_hold = draw_wait(rx_calm);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Waits until every base is taken and every word has come, then lets the block drain.
  task automatic settle();
    do @(posedge clk);
    while (base_queue.size() != 0 || in_tvalid || minimizer_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the job length while the block is idle.
  task automatic set_length(logic [SEQ_W-1:0] len);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    job_length  = len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Picks one base: plain ACGT, a short repeating motif, or raw bytes.
  function automatic logic [CHAR_W-1:0] pick_base(int mode, int idx,
                                                  logic [CHAR_W-1:0] motif[4], int period);
    logic [CHAR_W-1:0] acgt[4];
    acgt = '{ckm_pkg::ASCII_A, ckm_pkg::ASCII_C, ckm_pkg::ASCII_G, ckm_pkg::ASCII_T};
    case (mode)
      0: begin
        if ($urandom_range(0, 9) == 0) return CHAR_W'($urandom_range(0, 255));
        return acgt[$urandom_range(0, 3)];
      end
      1: begin
        if ($urandom_range(0, 29) == 0) return CHAR_W'($urandom_range(0, 255));
        return motif[idx % period];
      end
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues one run of bases in the given content style.
  task automatic queue_bases(int count, int mode);
    logic [CHAR_W-1:0] motif[4];
    logic [CHAR_W-1:0] acgt[4];
    int                period;
    acgt   = '{ckm_pkg::ASCII_A, ckm_pkg::ASCII_C, ckm_pkg::ASCII_G, ckm_pkg::ASCII_T};
    period = $urandom_range(1, 4);
    for (int p = 0; p < 4; p++) motif[p] = acgt[$urandom_range(0, 3)];
    for (int i = 0; i < count; i++) base_queue.push_back(pick_base(mode, i, motif, period));
  endtask

  // Timeout guard.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset, then directed jobs, random jobs and the length extremes.
  initial begin
    logic [SEQ_W-1:0] len;
    int               sent;
    int               job;
    int               mode;
    int               pick;
    rst_n       = 1'b0;
    in_tdata    = '0;
    in_tvalid   = 1'b0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    cycle_count = 0;
    tx_hold     = 0;
    tx_calm     = 0;
    rx_hold     = 0;
    rx_calm     = 0;
    job_length  = '0;
    clear_job();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A job too short for any k-mer: only an end word with count zero.
    set_length(SEQ_W'(8));
    base_queue.push_back(ckm_pkg::ASCII_A);
    base_queue.push_back(ckm_pkg::ASCII_C);
    base_queue.push_back(ckm_pkg::ASCII_G);
    base_queue.push_back(ckm_pkg::ASCII_T);
    base_queue.push_back(8'h00);
    base_queue.push_back(8'hFF);
    base_queue.push_back(8'h61);
    base_queue.push_back(8'h4E);

    // Single-base job.
    set_length(SEQ_W'(1));
    base_queue.push_back(ckm_pkg::ASCII_T);

    // Random jobs; the first three hit one k-mer, a window filling on the
    // last base, and the first base after a full window.
    sent = 9;
    job  = 0;
    while (sent < TARGET_BASES) begin
      case (job)
        0: len = SEQ_W'(KMER_LEN);
        1: len = SEQ_W'(KMER_LEN + WIN_LEN - 1);
        2: len = SEQ_W'(KMER_LEN + WIN_LEN);
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 2) len = SEQ_W'($urandom_range(1, KMER_LEN - 1));
          else if (pick == 2) len = SEQ_W'($urandom_range(KMER_LEN, KMER_LEN + WIN_LEN - 2));
          else if (pick == 3) len = SEQ_W'(KMER_LEN + WIN_LEN - 1);
          else if (pick < 9) len = SEQ_W'($urandom_range(KMER_LEN + WIN_LEN, 150));
          else len = SEQ_W'($urandom_range(151, 400));
        end
      endcase
      if (job < 3) mode = 1;
      else begin
        pick = $urandom_range(0, 9);
        mode = (pick < 6) ? 0 : (pick < 9) ? 1 : 2;
      end
      set_length(len);
      queue_bases(int'(len), mode);
      sent += int'(len);
      job++;
    end

    // Length zero and all ones: the job runs on with no end word.
    set_length('0);
    queue_bases(80, 0);
    set_length('1);
    queue_bases(40, 1);

    // Close the running job with a length just ahead of its count.
    settle();
    set_length(job_bases + SEQ_W'(20));
    queue_bases(20, 0);

    settle();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
